// ===== src/cvaa_pkg.sv =====
`default_nettype none
package cvaa_pkg;

  // Fixed widths of the stream fields
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned EXT_W   = 64;

  localparam int unsigned IN_TDATA_W  = 2 * FIELD_W;
  localparam int unsigned OUT_TDATA_W = 2 * FIELD_W + POS_W;

  // Step control from the pipeline to the minimum tracker
  typedef struct packed {
    logic advance;
    logic last;
  } step_ctrl_t;

endpackage
`default_nettype wire

// ===== src/inf_cost_vector_add_argmin.sv =====
`default_nettype none
// Channel  Dir  Handshake          Payload
// in_      in   in_tvalid/tready   tdata: cost, addend; tlast: last
// out_     out  out_tvalid/tready  tdata: sum, min_cost, min_position;
//                                  tuser: overflow; tlast: done_res
//
// One item per cycle sustained while out_tready holds; a taken item is held in the input
// register and its result captured in the result register. The rate is set by the single
// stage that holds the saturating add and the signed compare against the running minimum.
// Synchronous active-low reset empties both registers and sets the running
// minimum to infinity, its position and the element count to zero.
// A stalled output holds its result; the input register keeps taking items
// while the output register is being drained in the same cycle.
module inf_cost_vector_add_argmin #(
  parameter int unsigned COST_WIDTH = 32,
  parameter int unsigned MAX_LENGTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [cvaa_pkg::IN_TDATA_W-1:0]     in_tdata,  // cost[31:0], addend[63:32]
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [cvaa_pkg::OUT_TDATA_W-1:0]    out_tdata, // sum, min_cost, min_position
  output logic                                     out_tuser, // overflow
  output logic                                     out_tlast
);

  localparam int unsigned FW    = cvaa_pkg::FIELD_W;
  localparam int unsigned IDX_W = $clog2(MAX_LENGTH);

  // Input register
  logic                  s1_valid_r, s1_valid_nxt;
  logic [FW-1:0]         s1_cost_r;
  logic [FW-1:0]         s1_addend_r;
  logic                  s1_last_r;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  logic [FW-1:0]         out_sum_r;
  logic [FW-1:0]         out_min_r;
  logic [cvaa_pkg::POS_W-1:0] out_pos_r;
  logic                  out_ovf_r;
  logic                  out_last_r;

  logic                  in_acc;
  logic                  s1_adv;

  logic [cvaa_pkg::EXT_W-1:0] cost_ext, addend_ext, sum_ext, min_ext, pos_ext;
  logic [COST_WIDTH-1:0]      cost_w, addend_w, sum_w, min_w;
  logic [IDX_W-1:0]           pos_w;
  logic                       ovf_w;
  cvaa_pkg::step_ctrl_t       ctrl;

  // Advance the held item whenever the result register is empty or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Sign-extend the 32-bit operands, then take the cost width
  assign cost_ext   = cvaa_pkg::EXT_W'($signed(s1_cost_r));
  assign addend_ext = cvaa_pkg::EXT_W'($signed(s1_addend_r));
  assign cost_w     = cost_ext[COST_WIDTH-1:0];
  assign addend_w   = addend_ext[COST_WIDTH-1:0];

  cvaa_sat_add #(
    .COST_WIDTH (COST_WIDTH)
  ) u_add (
    .cost     (cost_w),
    .addend   (addend_w),
    .sum      (sum_w),
    .overflow (ovf_w)
  );

  assign ctrl.advance = s1_adv;
  assign ctrl.last    = s1_last_r;

  cvaa_min_track #(
    .COST_WIDTH (COST_WIDTH),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .sum          (sum_w),
    .min_cost     (min_w),
    .min_position (pos_w)
  );

  // Results carry the low bits of the cost-width values
  assign sum_ext = cvaa_pkg::EXT_W'(sum_w);
  assign min_ext = cvaa_pkg::EXT_W'(min_w);
  assign pos_ext = cvaa_pkg::EXT_W'(pos_w);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the item until it moves on
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cost_r   <= in_tdata[FW-1:0];
      s1_addend_r <= in_tdata[2*FW-1:FW];
      s1_last_r   <= in_tlast;
    end
  end

  // Capture the result; minimum fields read zero except on the last element
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sum_r  <= sum_ext[FW-1:0];
      out_ovf_r  <= ovf_w;
      out_last_r <= s1_last_r;
      out_min_r  <= s1_last_r ? min_ext[FW-1:0] : '0;
      out_pos_r  <= s1_last_r ? pos_ext[cvaa_pkg::POS_W-1:0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_r, out_min_r, out_sum_r};
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

  a_min_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> (out_min_r == '0) && (out_pos_r == '0))
    else $error("minimum reported on an element that is not last");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty input register");

  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item lost before the result register");

endmodule
`default_nettype wire

// ===== src/cvaa_sat_add.sv =====
`default_nettype none
module cvaa_sat_add #(
  parameter int unsigned COST_WIDTH = 32
) (
  input  wire logic [COST_WIDTH-1:0] cost,
  input  wire logic [COST_WIDTH-1:0] addend,
  output logic      [COST_WIDTH-1:0] sum,
  output logic                       overflow
);

  localparam logic [COST_WIDTH-1:0] CINF = {1'b0, {(COST_WIDTH-1){1'b1}}};
  localparam logic [COST_WIDTH-1:0] CMIN = {1'b1, {(COST_WIDTH-1){1'b0}}};

  logic [COST_WIDTH-1:0] raw;
  logic                  sign_flip;

  assign raw       = cost + addend;
  assign sign_flip = (cost[COST_WIDTH-1] == addend[COST_WIDTH-1]) &&
                     (raw[COST_WIDTH-1] != cost[COST_WIDTH-1]);

  always_comb begin
    sum      = raw;
    overflow = 1'b0;
    if ((cost == CINF) || (addend == CINF)) begin
      sum = CINF;
    end else if (sign_flip) begin
      // saturate towards the sign of the operands
      sum      = cost[COST_WIDTH-1] ? CMIN : CINF;
      overflow = 1'b1;
    end else if (raw == CINF) begin
      overflow = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/cvaa_min_track.sv =====
`default_nettype none
module cvaa_min_track #(
  parameter int unsigned COST_WIDTH = 32,
  parameter int unsigned MAX_LENGTH = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cvaa_pkg::step_ctrl_t              ctrl,
  input  wire logic [COST_WIDTH-1:0]             sum,
  output logic      [COST_WIDTH-1:0]             min_cost,
  output logic      [$clog2(MAX_LENGTH)-1:0]     min_position
);

  localparam int unsigned IDX_W = $clog2(MAX_LENGTH);
  localparam logic [COST_WIDTH-1:0] CINF = {1'b0, {(COST_WIDTH-1){1'b1}}};
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LENGTH - 1);

  logic [COST_WIDTH-1:0] run_min_r, run_min_nxt;
  logic [IDX_W-1:0]      run_pos_r, run_pos_nxt;
  logic [IDX_W-1:0]      count_r, count_nxt;
  logic                  take;

  assign take = $signed(sum) < $signed(run_min_r);

  // minimum including the current element
  assign min_cost     = take ? sum : run_min_r;
  assign min_position = take ? count_r : run_pos_r;

  always_comb begin
    run_min_nxt = run_min_r;
    run_pos_nxt = run_pos_r;
    count_nxt   = count_r;
    if (ctrl.advance) begin
      if (ctrl.last) begin
        run_min_nxt = CINF;
        run_pos_nxt = '0;
        count_nxt   = '0;
      end else begin
        run_min_nxt = min_cost;
        run_pos_nxt = min_position;
        count_nxt   = (count_r == IDX_LAST) ? '0 : count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r <= CINF;
      run_pos_r <= '0;
      count_r   <= '0;
    end else begin
      run_min_r <= run_min_nxt;
      run_pos_r <= run_pos_nxt;
      count_r   <= count_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.advance && ctrl.last |=> (count_r == '0) && (run_min_r == CINF) && (run_pos_r == '0))
    else $error("running state not cleared after last element");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.advance |=> $stable(count_r) && $stable(run_min_r) && $stable(run_pos_r))
    else $error("running state moved without an element");

  a_pos_inf: assert property (@(posedge clk) disable iff (!rst_n)
    (run_min_r == CINF) |-> (run_pos_r == '0))
    else $error("minimum position set while the minimum is still infinite");

endmodule
`default_nettype wire
